/* rtl/core/bde_pkg.sv */
// ----------------------------------------------------------------------------
// bde_pkg
// Shared constants and types of the bounded deque engine: command codes,
// result codes, and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package bde_pkg;

   // Default capacity of the sequence.
   localparam int DEPTH_DEFAULT = 32;

   // Command codes of an input transaction.
   localparam logic [3:0] CMD_PUSH_FRONT  = 4'd0;
   localparam logic [3:0] CMD_PUSH_BACK   = 4'd1;
   localparam logic [3:0] CMD_POP_FRONT   = 4'd2;
   localparam logic [3:0] CMD_POP_BACK    = 4'd3;
   localparam logic [3:0] CMD_CLEAR       = 4'd4;
   localparam logic [3:0] CMD_REMOVE      = 4'd5;
   localparam logic [3:0] CMD_PRINT_ALL   = 4'd6;
   localparam logic [3:0] CMD_PRINT_FIRST = 4'd7;
   localparam logic [3:0] CMD_PRINT_LAST  = 4'd8;

   // Result kinds.
   localparam logic [1:0] KIND_VALUE  = 2'd0;
   localparam logic [1:0] KIND_EOL    = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      DP_NOP,
      DP_PUSH_FRONT,
      DP_PUSH_BACK,
      DP_POP_FRONT,
      DP_LEN_DEC,
      DP_CLEAR,
      DP_LOAD_SEARCH,
      DP_SRCH_RD,
      DP_IDX_INC,
      DP_SHIFT_RD,
      DP_SHIFT_WR,
      DP_LOAD_ALL,
      DP_LOAD_FIRST,
      DP_LOAD_LAST,
      DP_PRINT_RD,
      DP_PRINT_NEXT
   } dp_op_type;

   // Command bundle from the controller to the datapath.
   typedef struct packed {
      dp_op_type  op;
      logic       emit;
      logic [1:0] kind;
      logic [1:0] status;
      logic       last;
   } ctl_type;

   // Status bundle from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic match;
      logic srch_more;
      logic prt_more;
   } sts_type;

endpackage

/* rtl/core/bde_ram.sv */
// ----------------------------------------------------------------------------
// bde_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = bde_pkg::DEPTH_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/bde_dpath.sv */
// ----------------------------------------------------------------------------
// bde_dpath
// Datapath of the bounded deque engine: front pointer, length, walk
// counters, the entry store and the result registers.
// ----------------------------------------------------------------------------
module bde_dpath #(
   parameter int DEPTH = bde_pkg::DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  bde_pkg::ctl_type    ctl,
   output bde_pkg::sts_type    sts,
   input  logic signed [31:0]  req_operand,
   output logic                rsp_valid,
   output logic [1:0]          rsp_kind,
   output logic signed [31:0]  rsp_value,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   logic [IW-1:0] front_ff, front_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [31:0]   operand_ff, operand_in;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_kind_ff;
   logic [31:0]   rsp_value_ff;
   logic [1:0]    rsp_status_ff;
   logic          rsp_last_ff;

   logic [LW-1:0] idx_next;
   logic [LW-1:0] offset;
   logic [LW:0]   slot_sum;
   logic [LW:0]   slot_wrap;
   logic [IW-1:0] slot_addr;
   logic [IW-1:0] front_dec;
   logic [IW-1:0] front_inc;
   logic [31:0]   opu;
   logic [LW-1:0] print_n;

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [31:0]   ram_wdata;
   logic          ram_re;
   logic [31:0]   ram_rdata;

   assign idx_next = idx_ff + 1'b1;
   assign opu      = req_operand;

   // Offset from the front that the current operation addresses.
   always_comb begin
      case (ctl.op)
         bde_pkg::DP_PUSH_BACK: offset = len_ff;
         bde_pkg::DP_SRCH_RD:   offset = idx_ff;
         bde_pkg::DP_SHIFT_WR:  offset = idx_ff;
         bde_pkg::DP_SHIFT_RD:  offset = idx_next;
         default:               offset = pos_ff;
      endcase
   end

   // Circular slot: front plus offset, wrapped once at the capacity.
   assign slot_sum  = (LW + 1)'(front_ff) + (LW + 1)'(offset);
   assign slot_wrap = (slot_sum >= (LW + 1)'(DEPTH)) ? slot_sum - (LW + 1)'(DEPTH)
                                                     : slot_sum;
   assign slot_addr = slot_wrap[IW-1:0];

   assign front_dec = (front_ff == '0) ? IW'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IW'(DEPTH - 1)) ? '0 : front_ff + 1'b1;

   // Print count: negative reads as zero, beyond the length reads as the length.
   always_comb begin
      if (opu[31]) begin
         print_n = '0;
      end else if (opu > 32'(len_ff)) begin
         print_n = len_ff;
      end else begin
         print_n = opu[LW-1:0];
      end
   end

   // Entry store access.
   assign ram_we    = (ctl.op == bde_pkg::DP_PUSH_FRONT) || (ctl.op == bde_pkg::DP_PUSH_BACK)
                   || (ctl.op == bde_pkg::DP_SHIFT_WR);
   assign ram_waddr = (ctl.op == bde_pkg::DP_PUSH_FRONT) ? front_dec : slot_addr;
   assign ram_wdata = (ctl.op == bde_pkg::DP_SHIFT_WR) ? ram_rdata : opu;
   assign ram_re    = (ctl.op == bde_pkg::DP_SRCH_RD) || (ctl.op == bde_pkg::DP_SHIFT_RD)
                   || (ctl.op == bde_pkg::DP_PRINT_RD);

   bde_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (slot_addr),
      .rdata (ram_rdata)
   );

   // Next values of the pointers and counters.
   always_comb begin
      front_in   = front_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      operand_in = operand_ff;
      case (ctl.op)
         bde_pkg::DP_PUSH_FRONT: begin
            front_in = front_dec;
            len_in   = len_ff + 1'b1;
         end
         bde_pkg::DP_PUSH_BACK: begin
            len_in = len_ff + 1'b1;
         end
         bde_pkg::DP_POP_FRONT: begin
            front_in = front_inc;
            len_in   = len_ff - 1'b1;
         end
         bde_pkg::DP_LEN_DEC: begin
            len_in = len_ff - 1'b1;
         end
         bde_pkg::DP_CLEAR: begin
            front_in = '0;
            len_in   = '0;
         end
         bde_pkg::DP_LOAD_SEARCH: begin
            operand_in = opu;
            idx_in     = '0;
         end
         bde_pkg::DP_IDX_INC, bde_pkg::DP_SHIFT_WR: begin
            idx_in = idx_next;
         end
         bde_pkg::DP_LOAD_ALL: begin
            pos_in = '0;
            cnt_in = len_ff;
         end
         bde_pkg::DP_LOAD_FIRST: begin
            pos_in = '0;
            cnt_in = print_n;
         end
         bde_pkg::DP_LOAD_LAST: begin
            pos_in = len_ff - print_n;
            cnt_in = print_n;
         end
         bde_pkg::DP_PRINT_NEXT: begin
            pos_in = pos_ff + 1'b1;
            cnt_in = cnt_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Sequence state is cleared by reset; walk registers are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         len_ff   <= '0;
      end else begin
         front_ff <= front_in;
         len_ff   <= len_in;
      end
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      cnt_ff     <= cnt_in;
      operand_ff <= operand_in;
   end

   // Result register: one transaction per strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.emit;
      end
      rsp_kind_ff   <= ctl.kind;
      rsp_status_ff <= ctl.status;
      rsp_last_ff   <= ctl.last;
      rsp_value_ff  <= (ctl.kind == bde_pkg::KIND_VALUE) ? ram_rdata : 32'd0;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   // Status toward the controller.
   assign sts.full      = (len_ff == LW'(DEPTH));
   assign sts.empty     = (len_ff == '0);
   assign sts.match     = (ram_rdata == operand_ff);
   assign sts.srch_more = (idx_next < len_ff);
   assign sts.prt_more  = (cnt_ff != '0);

endmodule

/* rtl/core/bde_ctrl.sv */
// ----------------------------------------------------------------------------
// bde_ctrl
// Controller of the bounded deque engine: decodes a command, sequences the
// search, compaction and print walks, and tells the datapath what to emit.
// ----------------------------------------------------------------------------
module bde_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [3:0]        req_command,
   input  bde_pkg::sts_type  sts,
   output bde_pkg::ctl_type  ctl
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SRCH_RD  = 7'b0000010,
      S_SRCH_CMP = 7'b0000100,
      S_SHIFT_RD = 7'b0001000,
      S_SHIFT_WR = 7'b0010000,
      S_PRT_RD   = 7'b0100000,
      S_PRT_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath command.
   always_comb begin
      state_in   = state_ff;
      ctl.op     = bde_pkg::DP_NOP;
      ctl.emit   = 1'b0;
      ctl.kind   = bde_pkg::KIND_STATUS;
      ctl.status = bde_pkg::ST_DONE;
      ctl.last   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_command)
                  bde_pkg::CMD_PUSH_FRONT: begin
                     ctl.emit = 1'b1;
                     if (sts.full) begin
                        ctl.status = bde_pkg::ST_FULL;
                     end else begin
                        ctl.op = bde_pkg::DP_PUSH_FRONT;
                     end
                  end
                  bde_pkg::CMD_PUSH_BACK: begin
                     ctl.emit = 1'b1;
                     if (sts.full) begin
                        ctl.status = bde_pkg::ST_FULL;
                     end else begin
                        ctl.op = bde_pkg::DP_PUSH_BACK;
                     end
                  end
                  bde_pkg::CMD_POP_FRONT: begin
                     ctl.emit = 1'b1;
                     if (sts.empty) begin
                        ctl.status = bde_pkg::ST_MISS;
                     end else begin
                        ctl.op = bde_pkg::DP_POP_FRONT;
                     end
                  end
                  bde_pkg::CMD_POP_BACK: begin
                     ctl.emit = 1'b1;
                     if (sts.empty) begin
                        ctl.status = bde_pkg::ST_MISS;
                     end else begin
                        ctl.op = bde_pkg::DP_LEN_DEC;
                     end
                  end
                  bde_pkg::CMD_CLEAR: begin
                     ctl.emit = 1'b1;
                     ctl.op   = bde_pkg::DP_CLEAR;
                  end
                  bde_pkg::CMD_REMOVE: begin
                     if (sts.empty) begin
                        ctl.emit   = 1'b1;
                        ctl.status = bde_pkg::ST_MISS;
                     end else begin
                        ctl.op   = bde_pkg::DP_LOAD_SEARCH;
                        state_in = S_SRCH_RD;
                     end
                  end
                  bde_pkg::CMD_PRINT_ALL: begin
                     ctl.op   = bde_pkg::DP_LOAD_ALL;
                     state_in = S_PRT_RD;
                  end
                  bde_pkg::CMD_PRINT_FIRST: begin
                     ctl.op   = bde_pkg::DP_LOAD_FIRST;
                     state_in = S_PRT_RD;
                  end
                  bde_pkg::CMD_PRINT_LAST: begin
                     ctl.op   = bde_pkg::DP_LOAD_LAST;
                     state_in = S_PRT_RD;
                  end
                  default: begin
                     // Unused codes answer done and change nothing.
                     ctl.emit = 1'b1;
                  end
               endcase
            end
         end
         S_SRCH_RD: begin
            ctl.op   = bde_pkg::DP_SRCH_RD;
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (sts.match) begin
               state_in = S_SHIFT_RD;
            end else if (sts.srch_more) begin
               ctl.op   = bde_pkg::DP_IDX_INC;
               state_in = S_SRCH_RD;
            end else begin
               ctl.emit   = 1'b1;
               ctl.status = bde_pkg::ST_MISS;
               state_in   = S_IDLE;
            end
         end
         S_SHIFT_RD: begin
            // Close the gap one entry at a time, then drop the tail.
            if (sts.srch_more) begin
               ctl.op   = bde_pkg::DP_SHIFT_RD;
               state_in = S_SHIFT_WR;
            end else begin
               ctl.op   = bde_pkg::DP_LEN_DEC;
               ctl.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SHIFT_WR: begin
            ctl.op   = bde_pkg::DP_SHIFT_WR;
            state_in = S_SHIFT_RD;
         end
         S_PRT_RD: begin
            if (sts.prt_more) begin
               ctl.op   = bde_pkg::DP_PRINT_RD;
               state_in = S_PRT_OUT;
            end else begin
               ctl.emit = 1'b1;
               ctl.kind = bde_pkg::KIND_EOL;
               state_in = S_IDLE;
            end
         end
         S_PRT_OUT: begin
            ctl.op   = bde_pkg::DP_PRINT_NEXT;
            ctl.emit = 1'b1;
            ctl.kind = bde_pkg::KIND_VALUE;
            ctl.last = 1'b0;
            state_in = S_PRT_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* rtl/core/bounded_deque_engine.sv */
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of signed 32-bit values with remove-by-value
// and print commands.
// ----------------------------------------------------------------------------
// Usage:
// A command transaction is taken when start is high and busy is low; it
// carries req_command and req_operand. Results appear on the rsp_ ports for
// one cycle each, marked by rsp_valid, and cannot be held off.
// Push, pop, clear and unused codes answer with one status transaction in
// the cycle after acceptance and leave busy low, so a new command can follow
// in the next cycle.
// Remove walks the sequence with a read state and a compare state per entry
// while searching (single registered read port of the entry store), then with
// a read state and a write state per entry that closes the gap; its status
// transaction ends the command.
// A print emits its values one at a time, read and output alternating on
// the store's read port, then the line-end transaction marked rsp_last.
// Reset empties the sequence and returns the front pointer to zero; no
// clearing pass is needed. Results leave through a register, so busy falls
// while the final result of a command is still on the ports.
// ----------------------------------------------------------------------------
module bounded_deque_engine #(
   parameter int DEPTH = bde_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_command,
   input  logic signed [31:0] req_operand,
   output logic               rsp_valid,
   output logic [1:0]         rsp_kind,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   bde_pkg::ctl_type ctl;
   bde_pkg::sts_type sts;

   // Command decode and sequencing.
   bde_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .sts         (sts),
      .ctl         (ctl)
   );

   // Storage, pointers and result register.
   bde_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .sts         (sts),
      .req_operand (req_operand),
      .rsp_valid   (rsp_valid),
      .rsp_kind    (rsp_kind),
      .rsp_value   (rsp_value),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last)
   );

endmodule
